FILE: hdl/aabb_triangle_overlap_macros.svh
// Assertion macros used by the top level of the triangle/box overlap RTL.
`ifndef AABB_TRIANGLE_OVERLAP_MACROS_SVH
`define AABB_TRIANGLE_OVERLAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ato: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATO_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ato: next-cycle check failed");

`endif

FILE: hdl/ato_pkg.sv
// Shared widths, types and constants for the triangle/box overlap pipeline.
package ato_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int HW  = 31;                          // half extent width
    localparam int VW  = COORD_WIDTH + 1;             // vertex relative to center
    localparam int EW  = COORD_WIDTH + 2;             // edge vector
    localparam int PW  = EW + VW;                     // edge x vertex product
    localparam int MW  = (VW > HW) ? VW : HW;
    localparam int TW  = EW + MW + 2;                 // projection / radius
    localparam int LW  = MW + 2;                      // box corner minus vertex
    localparam int NW  = 2 * EW + 1;                  // normal component
    localparam int NLO = NW / 2;                      // low split of normal
    localparam int NHI = NW - NLO;
    localparam int DW  = NW + LW + 2;                 // plane distance sum
    localparam int NSTAGE = 7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [VW-1:0]          vcoord_t;
    typedef logic signed [EW-1:0]          edge_t;
    typedef logic        [HW-1:0]          half_t;
    typedef logic signed [LW-1:0]          corner_t;

    typedef struct packed {
        logic [NSTAGE:1] en;   // stage s loads when en[s]
    } pipe_ctrl_t;

    typedef enum logic [1:0] {
        REG_HALF_X = 2'd0,
        REG_HALF_Y = 2'd1,
        REG_HALF_Z = 2'd2
    } cfg_reg_t;

    localparam logic [HW-1:0] HALF_RESET = HW'(65536);

    // Vertex pair projected for edge i against axis k.
    function automatic int vpair_a(input int i, input int k);
        int r;
        r = 0;
        if (i == 0 && k == 2) r = 1;
        if (i == 2 && k == 2) r = 1;
        return r;
    endfunction

    function automatic int vpair_b(input int i, input int k);
        int r;
        r = 2;
        if (i == 1 && k == 2) r = 1;
        if (i == 2 && k != 2) r = 1;
        return r;
    endfunction

endpackage

FILE: hdl/ato_edge_test.sv
// One edge-cross-axis separating test, registered in pipeline stages 3 to 6.
module ato_edge_test (
    input  logic                   aclk,
    input  ato_pkg::pipe_ctrl_t    ctrl,
    input  ato_pkg::edge_t         e_c1,
    input  ato_pkg::edge_t         e_c2,
    input  ato_pkg::vcoord_t       va_c1,
    input  ato_pkg::vcoord_t       va_c2,
    input  ato_pkg::vcoord_t       vb_c1,
    input  ato_pkg::vcoord_t       vb_c2,
    input  ato_pkg::half_t         h_c1,
    input  ato_pkg::half_t         h_c2,
    output logic                   sep
);

    logic signed [ato_pkg::PW-1:0] pa1_next, pa2_next, pb1_next, pb2_next;
    logic signed [ato_pkg::PW-1:0] pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic [ato_pkg::EW-1:0]        ae1, ae2;
    logic [ato_pkg::EW+ato_pkg::HW-1:0] r1_next, r2_next, r1_reg, r2_reg;
    logic signed [ato_pkg::TW-1:0] pa_next, pb_next, rad_next;
    logic signed [ato_pkg::TW-1:0] pa_reg, pb_reg, rad_reg;
    logic signed [ato_pkg::TW-1:0] lo, hi;
    logic                          sep_next, sep5_reg, sep6_reg;

    // stage 3: products
    assign pa1_next = e_c2 * va_c1;
    assign pa2_next = e_c1 * va_c2;
    assign pb1_next = e_c2 * vb_c1;
    assign pb2_next = e_c1 * vb_c2;
    assign ae1 = e_c1[ato_pkg::EW-1] ? -e_c1 : e_c1;
    assign ae2 = e_c2[ato_pkg::EW-1] ? -e_c2 : e_c2;
    assign r1_next = (ato_pkg::EW+ato_pkg::HW)'(ae2) * (ato_pkg::EW+ato_pkg::HW)'(h_c1);
    assign r2_next = (ato_pkg::EW+ato_pkg::HW)'(ae1) * (ato_pkg::EW+ato_pkg::HW)'(h_c2);

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            pa1_reg <= pa1_next;
            pa2_reg <= pa2_next;
            pb1_reg <= pb1_next;
            pb2_reg <= pb2_next;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
    end

    // stage 4: projections and radius
    assign pa_next  = ato_pkg::TW'(pa1_reg) - ato_pkg::TW'(pa2_reg);
    assign pb_next  = ato_pkg::TW'(pb1_reg) - ato_pkg::TW'(pb2_reg);
    assign rad_next = $signed(ato_pkg::TW'(r1_reg)) + $signed(ato_pkg::TW'(r2_reg));

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            rad_reg <= rad_next;
        end
    end

    // stage 5: compare; touching does not separate
    assign lo = (pb_reg < pa_reg) ? pb_reg : pa_reg;
    assign hi = (pb_reg < pa_reg) ? pa_reg : pb_reg;
    assign sep_next = (lo > rad_reg) || (hi < -rad_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.en[5]) begin
            sep5_reg <= sep_next;
        end
        if (ctrl.en[6]) begin
            sep6_reg <= sep5_reg;
        end
    end

    assign sep = sep6_reg;

endmodule

FILE: hdl/ato_plane_test.sv
// Triangle plane against box test: normal, corner select, split products, sums.
module ato_plane_test (
    input  logic                   aclk,
    input  ato_pkg::pipe_ctrl_t    ctrl,
    input  ato_pkg::edge_t         e0 [3],
    input  ato_pkg::edge_t         e1 [3],
    input  ato_pkg::corner_t       hp [3],
    input  ato_pkg::corner_t       hn [3],
    output logic                   ok
);

    localparam int MPW = 2 * ato_pkg::EW;
    localparam int PHW = ato_pkg::NHI + ato_pkg::LW;
    localparam int PLW = ato_pkg::NLO + 1 + ato_pkg::LW;
    localparam int FW  = ato_pkg::NW + ato_pkg::LW;

    logic signed [MPW-1:0]          m_next [6];
    logic signed [MPW-1:0]          m_reg  [6];
    ato_pkg::corner_t               hp3_reg [3], hn3_reg [3], hp4_reg [3], hn4_reg [3];
    logic signed [ato_pkg::NW-1:0]  n_next [3];
    logic signed [ato_pkg::NW-1:0]  n_reg  [3];
    ato_pkg::corner_t               sel_lo [3], sel_hi [3];
    logic signed [ato_pkg::NHI-1:0] nhi [3];
    logic signed [ato_pkg::NLO:0]   nlo [3];
    logic signed [PHW-1:0]          phl_reg [3], phh_reg [3];
    logic signed [PLW-1:0]          pll_reg [3], plh_reg [3];
    logic signed [FW-1:0]           fmin_next [3], fmax_next [3];
    logic signed [FW-1:0]           fmin_reg [3], fmax_reg [3];
    logic signed [ato_pkg::DW-1:0]  dmin, dmax;

    // stage 3: cross product terms
    assign m_next[0] = e0[1] * e1[2];
    assign m_next[1] = e0[2] * e1[1];
    assign m_next[2] = e0[2] * e1[0];
    assign m_next[3] = e0[0] * e1[2];
    assign m_next[4] = e0[0] * e1[1];
    assign m_next[5] = e0[1] * e1[0];

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            m_reg   <= m_next;
            hp3_reg <= hp;
            hn3_reg <= hn;
        end
    end

    // stage 4: normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_next[k] = ato_pkg::NW'(m_reg[2*k]) - ato_pkg::NW'(m_reg[2*k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            n_reg   <= n_next;
            hp4_reg <= hp3_reg;
            hn4_reg <= hn3_reg;
        end
    end

    // stage 5: pick near/far corner per axis, split normal into two products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (n_reg[k] > 0) begin
                sel_lo[k] = hn4_reg[k];
                sel_hi[k] = hp4_reg[k];
            end else begin
                sel_lo[k] = hp4_reg[k];
                sel_hi[k] = hn4_reg[k];
            end
            nhi[k] = n_reg[k][ato_pkg::NW-1:ato_pkg::NLO];
            nlo[k] = $signed({1'b0, n_reg[k][ato_pkg::NLO-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[5]) begin
            for (int k = 0; k < 3; k++) begin
                phl_reg[k] <= PHW'(nhi[k]) * PHW'(sel_lo[k]);
                phh_reg[k] <= PHW'(nhi[k]) * PHW'(sel_hi[k]);
                pll_reg[k] <= PLW'(nlo[k]) * PLW'(sel_lo[k]);
                plh_reg[k] <= PLW'(nlo[k]) * PLW'(sel_hi[k]);
            end
        end
    end

    // stage 6: recombine partial products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fmin_next[k] = (FW'(phl_reg[k]) <<< ato_pkg::NLO) + FW'(pll_reg[k]);
            fmax_next[k] = (FW'(phh_reg[k]) <<< ato_pkg::NLO) + FW'(plh_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[6]) begin
            fmin_reg <= fmin_next;
            fmax_reg <= fmax_next;
        end
    end

    // overlap unless the near corner is above the plane or the far one below
    assign dmin = ato_pkg::DW'(fmin_reg[0]) + ato_pkg::DW'(fmin_reg[1])
                + ato_pkg::DW'(fmin_reg[2]);
    assign dmax = ato_pkg::DW'(fmax_reg[0]) + ato_pkg::DW'(fmax_reg[1])
                + ato_pkg::DW'(fmax_reg[2]);
    assign ok = (dmin <= 0) && (dmax >= 0);

endmodule

FILE: hdl/aabb_triangle_overlap.sv
// Top level of the streaming triangle versus axis-aligned box overlap test.
//
// Each transfer on the s_ channel carries a box center and three triangle
// vertices, all signed fixed point with 16 fraction bits; the box half
// extents come from three configuration registers (reset 1.0). The block
// applies the separating axis test (each edge crossed with each axis, three
// box-axis extents and the triangle plane against the box) with exact
// full-width products and returns one m_overlap bit per item, in order.
// Touching counts as overlap. A degenerate triangle (zero normal) is decided
// by the other twelve axes alone. The pipeline is seven register stages:
// a new item is taken every cycle unless a stalled m_ready has backed the
// pipeline up to stage 1, and each result is presented on m_valid by stage 7.
// The per-stage valid bits fill bubbles, so a stalled m_ready holds only the
// stages that are occupied. Write the half extents only while no item is in
// flight; a write to an index above two is dropped.
module aabb_triangle_overlap (
    input  logic                                aclk,
    input  logic                                aresetn,
    // item input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_center_x,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_center_y,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_center_z,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert0_x,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert0_y,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert0_z,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert1_x,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert1_y,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert1_z,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert2_x,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert2_y,
    input  logic signed [ato_pkg::COORD_WIDTH-1:0] s_vert2_z,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_overlap,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [ato_pkg::HW-1:0]              cfg_wr_data
);

    `include "aabb_triangle_overlap_macros.svh"

    ato_pkg::half_t       half_x_reg, half_y_reg, half_z_reg;
    ato_pkg::half_t       hsz [3];
    ato_pkg::pipe_ctrl_t  ctrl;
    logic [ato_pkg::NSTAGE:1] en;
    logic [ato_pkg::NSTAGE:1] vld_reg;
    logic [ato_pkg::NSTAGE:0] vld_in;

    ato_pkg::coord_t      cin [3];
    ato_pkg::coord_t      vin [3][3];
    ato_pkg::vcoord_t     v_next [3][3];
    ato_pkg::vcoord_t     v_reg  [3][3];
    ato_pkg::vcoord_t     v2_reg [3][3];
    ato_pkg::edge_t       e_next [3][3];
    ato_pkg::edge_t       e_reg  [3][3];
    ato_pkg::corner_t     hp_next [3], hn_next [3];
    ato_pkg::corner_t     hp_reg  [3], hn_reg  [3];
    ato_pkg::corner_t     hs [3], vmin [3], vmax [3];
    logic                 box_next;
    logic [6:2]           box_reg;
    logic [8:0]           edge_sep;
    logic                 plane_ok;
    logic                 overlap_reg;

    // ---------------------------------------------------------------
    // Configuration: plain writes, out-of-range index dropped
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_x_reg <= ato_pkg::HALF_RESET;
            half_y_reg <= ato_pkg::HALF_RESET;
            half_z_reg <= ato_pkg::HALF_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ato_pkg::REG_HALF_X: half_x_reg <= cfg_wr_data;
                ato_pkg::REG_HALF_Y: half_y_reg <= cfg_wr_data;
                ato_pkg::REG_HALF_Z: half_z_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign hsz[0] = half_x_reg;
    assign hsz[1] = half_y_reg;
    assign hsz[2] = half_z_reg;

    // ---------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or the stage
    // after it advances; the output stage advances when empty or on m_ready.
    // ---------------------------------------------------------------
    always_comb begin
        en[ato_pkg::NSTAGE] = !vld_reg[ato_pkg::NSTAGE] || m_ready;
        for (int s = ato_pkg::NSTAGE - 1; s >= 1; s--) begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign ctrl.en = en;
    assign s_ready = en[1];
    assign vld_in  = {vld_reg, s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 1; s <= ato_pkg::NSTAGE; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld_in[s-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: move the triangle so the box center is the origin
    // ---------------------------------------------------------------
    assign cin[0] = s_center_x;
    assign cin[1] = s_center_y;
    assign cin[2] = s_center_z;
    assign vin[0][0] = s_vert0_x;
    assign vin[0][1] = s_vert0_y;
    assign vin[0][2] = s_vert0_z;
    assign vin[1][0] = s_vert1_x;
    assign vin[1][1] = s_vert1_y;
    assign vin[1][2] = s_vert1_z;
    assign vin[2][0] = s_vert2_x;
    assign vin[2][1] = s_vert2_y;
    assign vin[2][2] = s_vert2_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                v_next[i][k] = ato_pkg::VW'(vin[i][k]) - ato_pkg::VW'(cin[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            v_reg <= v_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: edges, plane corner offsets and the box-axis tests
    // ---------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_next[0][k] = ato_pkg::EW'(v_reg[1][k]) - ato_pkg::EW'(v_reg[0][k]);
            e_next[1][k] = ato_pkg::EW'(v_reg[2][k]) - ato_pkg::EW'(v_reg[1][k]);
            e_next[2][k] = ato_pkg::EW'(v_reg[0][k]) - ato_pkg::EW'(v_reg[2][k]);
            hs[k]      = $signed(ato_pkg::LW'(hsz[k]));
            hp_next[k] = hs[k] - ato_pkg::LW'(v_reg[0][k]);
            hn_next[k] = -hs[k] - ato_pkg::LW'(v_reg[0][k]);
            vmin[k] = ato_pkg::LW'(v_reg[0][k]);
            vmax[k] = ato_pkg::LW'(v_reg[0][k]);
            for (int i = 1; i < 3; i++) begin
                if (ato_pkg::LW'(v_reg[i][k]) < vmin[k]) vmin[k] = ato_pkg::LW'(v_reg[i][k]);
                if (ato_pkg::LW'(v_reg[i][k]) > vmax[k]) vmax[k] = ato_pkg::LW'(v_reg[i][k]);
            end
        end
        box_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (vmin[k] > hs[k] || vmax[k] < -hs[k]) box_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            e_reg      <= e_next;
            v2_reg     <= v_reg;
            hp_reg     <= hp_next;
            hn_reg     <= hn_next;
            box_reg[2] <= box_next;
        end
    end

    // carry the box-axis verdict down to stage 6
    always_ff @(posedge aclk) begin
        for (int s = 3; s <= 6; s++) begin
            if (en[s]) begin
                box_reg[s] <= box_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 3 to 6: edge-axis tests for each edge and axis, and the plane test
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < 3; gi++) begin : g_edge
        for (genvar gk = 0; gk < 3; gk++) begin : g_axis
            localparam int C1 = (gk + 1) % 3;
            localparam int C2 = (gk + 2) % 3;
            localparam int VA = ato_pkg::vpair_a(gi, gk);
            localparam int VB = ato_pkg::vpair_b(gi, gk);

            ato_edge_test u_edge (
                .aclk  (aclk),
                .ctrl  (ctrl),
                .e_c1  (e_reg[gi][C1]),
                .e_c2  (e_reg[gi][C2]),
                .va_c1 (v2_reg[VA][C1]),
                .va_c2 (v2_reg[VA][C2]),
                .vb_c1 (v2_reg[VB][C1]),
                .vb_c2 (v2_reg[VB][C2]),
                .h_c1  (hsz[C1]),
                .h_c2  (hsz[C2]),
                .sep   (edge_sep[3*gi+gk])
            );
        end
    end

    ato_plane_test u_plane (
        .aclk (aclk),
        .ctrl (ctrl),
        .e0   (e_reg[0]),
        .e1   (e_reg[1]),
        .hp   (hp_reg),
        .hn   (hn_reg),
        .ok   (plane_ok)
    );

    // ---------------------------------------------------------------
    // Stage 7: combine verdicts into the output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en[7]) begin
            overlap_reg <= !(|edge_sep) && !box_reg[6] && plane_ok;
        end
    end

    assign m_valid   = vld_reg[ato_pkg::NSTAGE];
    assign m_overlap = overlap_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ATO_ASSERT_NXT(a_in_enters_s1, aclk, aresetn, s_valid && s_ready, vld_reg[1])
    `ATO_ASSERT_IMP(a_ready_when_s1_free, aclk, aresetn, !vld_reg[1], s_ready)
    `ATO_ASSERT_NXT(a_bubble_fills, aclk, aresetn, vld_reg[6] && !vld_reg[7], vld_reg[7])
    `ATO_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(overlap_reg))

endmodule

FILE: tb/sv/tb_aabb_triangle_overlap.sv
// Self-checking stream testbench for the triangle versus box overlap pipeline.
`timescale 1ns / 100ps

module tb_aabb_triangle_overlap;

    localparam int N_RANDOM   = 1700;
    localparam int WATCH_MAX  = 20000;
    localparam int DRAIN_WAIT = 2 * ato_pkg::NSTAGE + 4;
    // wide enough for every exact product and sum used below
    localparam int XW = 200;
    typedef logic signed [XW-1:0] xwide_t;

    // one triangle/box query: center then three vertices, x y z each
    typedef struct {
        ato_pkg::coord_t c [3];
        ato_pkg::coord_t v [3][3];
    } query_t;

    // directed row: the expected bit is typed in only where has_exp is set
    typedef struct {
        query_t q;
        bit     has_exp;
        bit     exp_bit;
    } stim_row_t;

    logic aclk;
    logic aresetn;

    logic   s_valid;
    logic   s_ready;
    ato_pkg::coord_t s_center_x, s_center_y, s_center_z;
    ato_pkg::coord_t s_vert0_x, s_vert0_y, s_vert0_z;
    ato_pkg::coord_t s_vert1_x, s_vert1_y, s_vert1_z;
    ato_pkg::coord_t s_vert2_x, s_vert2_y, s_vert2_z;
    logic   m_valid;
    logic   m_ready;
    logic   m_overlap;
    logic   cfg_wr_en;
    logic [1:0]    cfg_index;
    logic [ato_pkg::HW-1:0] cfg_wr_data;

    // shadow copy of the half extents
    ato_pkg::half_t half_ext [3];

    bit   overlap_q [$];
    int   fail_cnt;
    int   idle_cycles;

    aabb_triangle_overlap u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_center_x  (s_center_x),
        .s_center_y  (s_center_y),
        .s_center_z  (s_center_z),
        .s_vert0_x   (s_vert0_x),
        .s_vert0_y   (s_vert0_y),
        .s_vert0_z   (s_vert0_z),
        .s_vert1_x   (s_vert1_x),
        .s_vert1_y   (s_vert1_y),
        .s_vert1_z   (s_vert1_z),
        .s_vert2_x   (s_vert2_x),
        .s_vert2_y   (s_vert2_y),
        .s_vert2_z   (s_vert2_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_overlap   (m_overlap),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Separating axis test at full width. Returns 1 when the triangle touches
    // or overlaps the box.
    function automatic bit overlap_of(input query_t q);
        xwide_t v [3][3];
        xwide_t e [3][3];
        xwide_t h [3];
        xwide_t nrm [3];
        xwide_t pa, pb, rad, lo, hi, dmin, dmax, cmin, cmax;
        int c1, c2, a, b;
        for (int k = 0; k < 3; k++) h[k] = xwide_t'({1'b0, half_ext[k]});
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = xwide_t'(q.v[i][k]) - xwide_t'(q.c[k]);
        for (int k = 0; k < 3; k++) begin
            e[0][k] = v[1][k] - v[0][k];
            e[1][k] = v[2][k] - v[1][k];
            e[2][k] = v[0][k] - v[2][k];
        end
        // edge x axis projections, for each edge and each axis
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                c1 = (k + 1) % 3;
                c2 = (k + 2) % 3;
                a  = (i == 0 && k == 2) || (i == 2 && k == 2) ? 1 : 0;
                b  = (i == 1 && k == 2) || (i == 2 && k != 2) ? 1 : 2;
                pa = e[i][c2] * v[a][c1] - e[i][c1] * v[a][c2];
                pb = e[i][c2] * v[b][c1] - e[i][c1] * v[b][c2];
                rad = (e[i][c2] < 0 ? -e[i][c2] : e[i][c2]) * h[c1]
                    + (e[i][c1] < 0 ? -e[i][c1] : e[i][c1]) * h[c2];
                lo = (pb < pa) ? pb : pa;
                hi = (pb < pa) ? pa : pb;
                if (lo > rad || hi < -rad) return 1'b0;
            end
        end
        // box face axes
        for (int k = 0; k < 3; k++) begin
            lo = v[0][k];
            hi = v[0][k];
            for (int i = 1; i < 3; i++) begin
                if (v[i][k] < lo) lo = v[i][k];
                if (v[i][k] > hi) hi = v[i][k];
            end
            if (lo > h[k] || hi < -h[k]) return 1'b0;
        end
        // triangle plane; a zero normal component counts as not positive
        nrm[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        nrm[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        nrm[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        dmin = 0;
        dmax = 0;
        for (int k = 0; k < 3; k++) begin
            if (nrm[k] > 0) begin
                cmin = -h[k] - v[0][k];
                cmax =  h[k] - v[0][k];
            end else begin
                cmin =  h[k] - v[0][k];
                cmax = -h[k] - v[0][k];
            end
            dmin += nrm[k] * cmin;
            dmax += nrm[k] * cmax;
        end
        if (dmin > 0) return 1'b0;
        return dmax >= 0;
    endfunction

    function automatic ato_pkg::coord_t coord_of(input int x);
        return ato_pkg::coord_t'(x);
    endfunction

    // Random coordinate: mostly near the box so every axis gets exercised,
    // sometimes anywhere in the 32-bit range.
    function automatic ato_pkg::coord_t rand_coord(input ato_pkg::coord_t base);
        case ($urandom_range(0, 9))
            0, 1:    return ato_pkg::coord_t'($urandom);
            2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return base + ato_pkg::coord_t'($signed($urandom_range(0, 393216)) - 196608);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        ato_pkg::coord_t base [3];
        for (int k = 0; k < 3; k++) begin
            q.c[k] = ($urandom_range(0, 3) == 0)
                   ? ato_pkg::coord_t'($urandom)
                   : ato_pkg::coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            base[k] = q.c[k];
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                q.v[i][k] = rand_coord(base[k]);
        // occasional degenerate triangle: repeat a vertex
        if ($urandom_range(0, 15) == 0) q.v[2] = q.v[$urandom_range(0, 1)];
        return q;
    endfunction

    function automatic query_t make_query(input int cx, input int cy, input int cz,
                                          input int ax, input int ay, input int az,
                                          input int bx, input int by, input int bz,
                                          input int dx, input int dy, input int dz);
        query_t q;
        q.c[0] = coord_of(cx); q.c[1] = coord_of(cy); q.c[2] = coord_of(cz);
        q.v[0][0] = coord_of(ax); q.v[0][1] = coord_of(ay); q.v[0][2] = coord_of(az);
        q.v[1][0] = coord_of(bx); q.v[1][1] = coord_of(by); q.v[1][2] = coord_of(bz);
        q.v[2][0] = coord_of(dx); q.v[2][1] = coord_of(dy); q.v[2][2] = coord_of(dz);
        return q;
    endfunction

    // Drop s_valid and idle for a randomly drawn gap, sometimes none at all.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Present one query and hold it until the transfer.
    task automatic send_query(input query_t q, input bit has_exp, input bit exp_bit);
        bit pred;
        idle_gap();
        pred = overlap_of(q);
        s_valid    <= 1'b1;
        s_center_x <= q.c[0];    s_center_y <= q.c[1];    s_center_z <= q.c[2];
        s_vert0_x  <= q.v[0][0]; s_vert0_y  <= q.v[0][1]; s_vert0_z  <= q.v[0][2];
        s_vert1_x  <= q.v[1][0]; s_vert1_y  <= q.v[1][1]; s_vert1_z  <= q.v[1][2];
        s_vert2_x  <= q.v[2][0]; s_vert2_y  <= q.v[2][1]; s_vert2_z  <= q.v[2][2];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // typed-in row must agree with the predictor too
        if (has_exp && pred != exp_bit) begin
            $error("directed row: overlap expected %0d, predictor %0d", exp_bit, pred);
            fail_cnt++;
        end
        overlap_q.push_back(has_exp ? exp_bit : pred);
    endtask

    task automatic write_half(input ato_pkg::cfg_reg_t idx, input ato_pkg::half_t val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        half_ext[idx] = val;
        @(posedge aclk);
    endtask

    // Drop s_valid, drain outstanding results, then let the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Result side: random stalls on m_ready, compare each transfer in order.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (overlap_q.size() == 0) begin
                $error("overlap: result with nothing expected, actual %0d", m_overlap);
                fail_cnt++;
            end else begin
                bit exp_bit;
                exp_bit = overlap_q.pop_front();
                if (m_overlap !== exp_bit) begin
                    $error("overlap: expected %0d, actual %0d", exp_bit, m_overlap);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    stim_row_t rows [$];

    initial begin
        stim_row_t r;
        query_t q;
        ato_pkg::half_t hval;
        fail_cnt    = 0;
        idle_cycles = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = ato_pkg::REG_HALF_X;
        cfg_wr_data = '0;
        {s_center_x, s_center_y, s_center_z} = '0;
        {s_vert0_x, s_vert0_y, s_vert0_z}    = '0;
        {s_vert1_x, s_vert1_y, s_vert1_z}    = '0;
        {s_vert2_x, s_vert2_y, s_vert2_z}    = '0;
        for (int k = 0; k < 3; k++) half_ext[k] = ato_pkg::HALF_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, unit box from reset (1.0 = 65536).
        // triangle through the center: overlap
        r.has_exp = 1; r.exp_bit = 1;
        r.q = make_query(0, 0, 0, -65536, 0, 0, 65536, 0, 0, 0, 65536, 0);
        rows.push_back(r);
        // far along x: box-axis separation
        r.exp_bit = 0;
        r.q = make_query(0, 0, 0, 300000, 0, 0, 400000, 0, 0, 350000, 65536, 0);
        rows.push_back(r);
        // touches the +x face exactly: touching is overlap
        r.exp_bit = 1;
        r.q = make_query(0, 0, 0, 65536, -10, -10, 65536, 10, -10, 65536, 0, 10);
        rows.push_back(r);
        // just beyond the face by one lsb
        r.exp_bit = 0;
        r.q = make_query(0, 0, 0, 65537, -10, -10, 65537, 10, -10, 65537, 0, 10);
        rows.push_back(r);
        // degenerate triangle (all vertices equal) inside the box
        r.exp_bit = 1;
        r.q = make_query(0, 0, 0, 100, 100, 100, 100, 100, 100, 100, 100, 100);
        rows.push_back(r);
        // degenerate point outside
        r.exp_bit = 0;
        r.q = make_query(0, 0, 0, 200000, 0, 0, 200000, 0, 0, 200000, 0, 0);
        rows.push_back(r);
        // extreme coordinates, checked against the predictor
        r.has_exp = 0;
        r.q = make_query(32'sh7fffffff, 32'sh80000000, 0,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        rows.push_back(r);
        r.q = make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                         32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        rows.push_back(r);
        r.q = make_query(-1, -1, -1, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                         32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, -1, 0, 1);
        rows.push_back(r);
        // big triangle that spans the box diagonally, missing only by the plane
        r.q = make_query(0, 0, 0, 300000, 0, 0, 0, 300000, 0, 0, 0, 300000);
        rows.push_back(r);
        r.q = make_query(0, 0, 0, 150000, 0, 0, 0, 150000, 0, 0, 0, 150000);
        rows.push_back(r);
        // edge-axis separation near a box edge
        r.q = make_query(0, 0, 0, 140000, 0, -10000, 0, 140000, -10000, 140000, 0, 10000);
        rows.push_back(r);
        // offset center
        r.q = make_query(1000000, -1000000, 50, 1000000, -1000000, 50,
                         1100000, -1000000, 50, 1000000, -900000, 60000);
        rows.push_back(r);
        foreach (rows[i]) send_query(rows[i].q, rows[i].has_exp, rows[i].exp_bit);
        wait_drained();

        // Config phases: extremes then random extents, each with random traffic.
        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 3; k++) begin
                case (ph)
                    0:       hval = '0;
                    1:       hval = {ato_pkg::HW{1'b1}};
                    2:       hval = ato_pkg::half_t'(k == 0 ? 0 : 32'h7fffffff);
                    default: hval = ato_pkg::half_t'($urandom_range(0, 262144));
                endcase
                write_half(ato_pkg::cfg_reg_t'(k), hval);
            end
            cfg_wr_en <= 1'b0;
            for (int n = 0; n < (ph < 3 ? 100 : N_RANDOM / 3); n++) begin
                q = rand_query();
                send_query(q, 1'b0, 1'b0);
            end
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
